### hw/rtl/pwdm_pkg.sv
// Shared widths, limits, reset values and register codes for the pitch PID block.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package pwdm_pkg;

   localparam int ANGLE_W    = 17;
   localparam int ERR_W      = 18;
   localparam int DIFF_W     = 19;
   localparam int GAIN_W     = 16;
   localparam int DZ_W       = 16;
   localparam int PULSE_W    = 12;
   localparam int CORR_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int PROD_SHIFT = 16;

   localparam int CORR_MAX      = 2047;
   localparam int PULSE_MAX     = 4095;
   localparam int DEAD_ZONE_RST = 922;
   localparam int NEUTRAL_RST   = 1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_PROP     = 3'd0,
      REG_GAIN_INTEG    = 3'd1,
      REG_GAIN_DERIV    = 3'd2,
      REG_TARGET_ANGLE  = 3'd3,
      REG_DEAD_ZONE     = 3'd4,
      REG_NEUTRAL_PULSE = 3'd5
   } csr_reg_type;

endpackage

`default_nettype wire

### hw/rtl/pwdm_if.sv
// Valid/ready channel interfaces for the pitch PID block: sample in, pulses out, CSR writes.
// Depends on pwdm_pkg for field widths.
`default_nettype none

interface pwdm_req_if
   import pwdm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  angle_sample;

   modport source (output valid, output angle_sample, input ready);
   modport sink   (input valid, input angle_sample, output ready);
endinterface

interface pwdm_rsp_if
   import pwdm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] front_pulse;
   logic [PULSE_W-1:0] back_pulse;
   logic               loop_active;

   modport source (output valid, output front_pulse, output back_pulse, output loop_active,
                   input ready);
   modport sink   (input valid, input front_pulse, input back_pulse, input loop_active,
                   output ready);
endinterface

interface pwdm_csr_if
   import pwdm_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/pid_with_deadband_mixer.sv
// Pitch PID controller with dead band and front/back thruster mixer, top level.
// Depends on pwdm_pkg and the channel interfaces in pwdm_if.sv.
//
// Usage:
//   req_ch  : one signed angle sample per beat (1/256 degree).
//   rsp_ch  : one beat per sample: front pulse, back pulse, loop_active flag.
//   csr_ch  : register writes (gains, target, dead zone, neutral pulse); always ready.
//             Write only while no sample is in flight.
// Timing:
//   Four register stages: input, error/integral update, products, combine/clamp.
//   A sample moves through the input, error, product and result registers in turn.
//   One sample per cycle sustained while rsp_ch takes results; the integral and last-error recurrence
//   closes in the error stage with one saturating add, so samples may follow
//   each other every cycle.
// Reset:
//   Synchronous, active high. Clears the pipeline, the integral and the last
//   error, and loads the register defaults (dead zone 922, neutral 1500).
// Stall:
//   When rsp_ch is not taken, each stage holds; bubbles still collapse, so
//   req_ch stays ready until all four stages hold a result.
`default_nettype none

module pid_with_deadband_mixer
   import pwdm_pkg::*;
#(
   parameter int SUM_WIDTH = 32
) (
   input  wire          clock,
   input  wire          reset,
   pwdm_req_if.sink     req_ch,
   pwdm_rsp_if.source   rsp_ch,
   pwdm_csr_if.sink     csr_ch
);

   localparam int PI_W  = GAIN_W + SUM_WIDTH;
   localparam int PP_W  = GAIN_W + ERR_W;
   localparam int PD_W  = GAIN_W + DIFF_W;
   localparam int ACC_W = PI_W + 2;
   localparam int CW    = ACC_W - PROD_SHIFT;
   localparam int PW    = PULSE_W + 2;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
   localparam logic signed [CW-1:0]        CORR_HI = CW'(CORR_MAX);
   localparam logic signed [CW-1:0]        CORR_LO = -CW'(CORR_MAX);
   localparam logic signed [PW-1:0]        PULSE_HI = PW'(PULSE_MAX);

   // configuration registers
   logic signed [GAIN_W-1:0]  gain_prop_ff;
   logic signed [GAIN_W-1:0]  gain_integ_ff;
   logic signed [GAIN_W-1:0]  gain_deriv_ff;
   logic signed [ANGLE_W-1:0] target_angle_ff;
   logic [DZ_W-1:0]           dead_zone_ff;
   logic [PULSE_W-1:0]        neutral_pulse_ff;

   // controller state
   logic signed [SUM_WIDTH-1:0] error_sum_ff;
   logic signed [ERR_W-1:0]     last_error_ff;

   // pipeline valids and enables
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic a_ok, b_ok, c_ok, d_ok;

   // stage A: input register
   logic signed [ANGLE_W-1:0] a_angle_ff;

   // stage B: error, integral, difference
   logic signed [ERR_W-1:0]     b_err_ff,  b_err_in;
   logic signed [SUM_WIDTH-1:0] b_sum_ff,  b_sum_in;
   logic signed [DIFF_W-1:0]    b_diff_ff, b_diff_in;
   logic                        b_active_ff, b_active_in;
   logic [ERR_W-1:0]            err_mag;
   logic signed [SUM_WIDTH:0]   sum_wide;

   // stage C: products
   logic signed [PP_W-1:0] c_prop_ff,  c_prop_in;
   logic signed [PI_W-1:0] c_integ_ff, c_integ_in;
   logic signed [PD_W-1:0] c_deriv_ff, c_deriv_in;
   logic                   c_active_ff;

   // stage D: result register
   logic [PULSE_W-1:0] d_front_ff, d_front_in;
   logic [PULSE_W-1:0] d_back_ff,  d_back_in;
   logic               d_active_ff;

   logic signed [ACC_W-1:0]  acc;
   logic signed [CW-1:0]     corr_wide;
   logic signed [CORR_W-1:0] corr;
   logic signed [PW-1:0]     front_raw, back_raw;

   // ---------------------------------------------------------------- control
   assign d_ok = !d_valid_ff || rsp_ch.ready;
   assign c_ok = !c_valid_ff || d_ok;
   assign b_ok = !b_valid_ff || c_ok;
   assign a_ok = !a_valid_ff || b_ok;

   assign req_ch.ready = a_ok;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ok) a_valid_ff <= req_ch.valid;
         if (b_ok) b_valid_ff <= a_valid_ff;
         if (c_ok) c_valid_ff <= b_valid_ff;
         if (d_ok) d_valid_ff <= c_valid_ff;
      end
   end

   // ---------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff     <= '0;
         gain_integ_ff    <= '0;
         gain_deriv_ff    <= '0;
         target_angle_ff  <= '0;
         dead_zone_ff     <= DZ_W'(DEAD_ZONE_RST);
         neutral_pulse_ff <= PULSE_W'(NEUTRAL_RST);
      end else if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.reg_index))
            REG_GAIN_PROP:     gain_prop_ff     <= csr_ch.wdata[GAIN_W-1:0];
            REG_GAIN_INTEG:    gain_integ_ff    <= csr_ch.wdata[GAIN_W-1:0];
            REG_GAIN_DERIV:    gain_deriv_ff    <= csr_ch.wdata[GAIN_W-1:0];
            REG_TARGET_ANGLE:  target_angle_ff  <= csr_ch.wdata[ANGLE_W-1:0];
            REG_DEAD_ZONE:     dead_zone_ff     <= csr_ch.wdata[DZ_W-1:0];
            REG_NEUTRAL_PULSE: neutral_pulse_ff <= csr_ch.wdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage A
   always_ff @(posedge clock) begin
      if (a_ok) a_angle_ff <= req_ch.angle_sample;
   end

   // ---------------------------------------------------------------- stage B
   always_comb begin
      b_err_in    = ERR_W'(target_angle_ff) - ERR_W'(a_angle_ff);
      err_mag     = b_err_in[ERR_W-1] ? ERR_W'(-b_err_in) : ERR_W'(b_err_in);
      b_active_in = err_mag >= {{(ERR_W-DZ_W){1'b0}}, dead_zone_ff};

      // saturate the integral: overflow shows as differing top two bits
      sum_wide = {error_sum_ff[SUM_WIDTH-1], error_sum_ff} + (SUM_WIDTH+1)'(b_err_in);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         b_sum_in = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         b_sum_in = sum_wide[SUM_WIDTH-1:0];
      end

      b_diff_in = DIFF_W'(b_err_in) - DIFF_W'(last_error_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (a_valid_ff && b_ok && b_active_in) begin
         error_sum_ff  <= b_sum_in;
         last_error_ff <= b_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ok) begin
         b_err_ff    <= b_err_in;
         b_sum_ff    <= b_sum_in;
         b_diff_ff   <= b_diff_in;
         b_active_ff <= b_active_in;
      end
   end

   // ---------------------------------------------------------------- stage C
   always_comb begin
      c_prop_in  = gain_prop_ff  * b_err_ff;
      c_integ_in = gain_integ_ff * b_sum_ff;
      c_deriv_in = gain_deriv_ff * b_diff_ff;
   end

   always_ff @(posedge clock) begin
      if (c_ok) begin
         c_prop_ff   <= c_prop_in;
         c_integ_ff  <= c_integ_in;
         c_deriv_ff  <= c_deriv_in;
         c_active_ff <= b_active_ff;
      end
   end

   // ---------------------------------------------------------------- stage D
   always_comb begin
      acc       = ACC_W'(c_prop_ff) + ACC_W'(c_integ_ff) + ACC_W'(c_deriv_ff);
      // arithmetic shift rounds toward minus infinity
      corr_wide = CW'(acc >>> PROD_SHIFT);

      if (!c_active_ff) begin
         corr = '0;
      end else if (corr_wide > CORR_HI) begin
         corr = CORR_W'(CORR_HI);
      end else if (corr_wide < CORR_LO) begin
         corr = CORR_W'(CORR_LO);
      end else begin
         corr = corr_wide[CORR_W-1:0];
      end

      front_raw = $signed({2'b00, neutral_pulse_ff}) + PW'(corr);
      back_raw  = $signed({2'b00, neutral_pulse_ff}) - PW'(corr);

      if (front_raw < 0) begin
         d_front_in = '0;
      end else if (front_raw > PULSE_HI) begin
         d_front_in = PULSE_W'(PULSE_MAX);
      end else begin
         d_front_in = front_raw[PULSE_W-1:0];
      end

      if (back_raw < 0) begin
         d_back_in = '0;
      end else if (back_raw > PULSE_HI) begin
         d_back_in = PULSE_W'(PULSE_MAX);
      end else begin
         d_back_in = back_raw[PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (d_ok) begin
         d_front_ff  <= d_front_in;
         d_back_ff   <= d_back_in;
         d_active_ff <= c_active_ff;
      end
   end

   assign rsp_ch.valid       = d_valid_ff;
   assign rsp_ch.front_pulse = d_front_ff;
   assign rsp_ch.back_pulse  = d_back_ff;
   assign rsp_ch.loop_active = d_active_ff;

endmodule

`default_nettype wire
